// ===== src/dse_pkg.sv =====
// Shared types and constants for the dual-exponential synapse core.
package dse_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int STATE_WIDTH_DEF = 48;

    localparam int VALUE_W   = 32;
    localparam int COND_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int DECAY_W   = 17;
    localparam int DIGIT_W   = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_DECAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_DECAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_NORM  = 3'd4;

    // register reset values (raw bit patterns)
    localparam logic [CFG_W-1:0]   DRIVE_GAIN_RST = 32'd65536;
    localparam logic [DECAY_W-1:0] X_DECAY_RST    = 17'd65536;
    localparam logic [CFG_W-1:0]   Y_GAIN_RST     = 32'd0;
    localparam logic [DECAY_W-1:0] Y_DECAY_RST    = 17'd0;
    localparam logic [CFG_W-1:0]   PEAK_NORM_RST  = 32'd65536;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_MOD   = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // multiply steps, in tick order after OP_MOD
    typedef enum logic [2:0] {
        OP_MOD = 3'd0,  // gain * value
        OP_MA  = 3'd1,  // gain * activation
        OP_DRV = 3'd2,  // temp * drive_gain
        OP_XD  = 3'd3,  // x * x_decay, then x update
        OP_YG  = 3'd4,  // x * y_gain
        OP_YD  = 3'd5,  // y * y_decay, then y update
        OP_PK  = 3'd6   // y * peak_norm, then emit
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_MUL_GO   = 2'd1,
        ST_MUL_WAIT = 2'd2
    } state_t;

    typedef struct packed {
        logic load_val;
        logic act_add;
        logic clear;
        logic mul_start;
        logic wb;
        op_t  op;
    } dse_cmd_t;

    typedef struct packed {
        logic mul_busy;
    } dse_sts_t;

endpackage

// ===== src/dse_mul.sv =====
// Iterative signed fixed-point multiplier, one 16-bit digit per cycle, saturating.
module dse_mul #(
    parameter int FRAC_BITS   = dse_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = dse_pkg::STATE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [STATE_WIDTH-1:0] a,
    input  logic signed [STATE_WIDTH-1:0] b,
    output logic                          busy,
    output logic signed [STATE_WIDTH-1:0] result
);

    localparam int SW   = STATE_WIDTH;
    localparam int DGW  = dse_pkg::DIGIT_W;
    localparam int NDIG = (SW + DGW - 1) / DGW;
    localparam int DW   = NDIG * DGW;
    localparam int AW   = 2 * DW;
    localparam int PW   = AW + 1;
    localparam int CW   = $clog2(NDIG + 1);

    localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

    logic                 busy_reg;
    logic [CW-1:0]        cnt_reg;
    logic [DW-1:0]        mag_a_reg;
    logic [DW-1:0]        mag_b_reg;
    logic [AW-1:0]        acc_reg;
    logic                 neg_reg;
    logic signed [SW-1:0] res_reg;

    logic [SW-1:0]        abs_a;
    logic [SW-1:0]        abs_b;
    logic [DGW-1:0]       digit;
    logic [DW+DGW-1:0]    pp;
    logic [AW-1:0]        acc_next;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] shifted;
    logic                 fits;
    logic signed [SW-1:0] sat_val;

    always_comb begin
        abs_a    = a[SW-1] ? (~a + 1'b1) : a;
        abs_b    = b[SW-1] ? (~b + 1'b1) : b;
        digit    = mag_b_reg[DW-1 -: DGW];
        pp       = mag_a_reg * digit;
        acc_next = {acc_reg[AW-DGW-1:0], {DGW{1'b0}}} + AW'(pp);
        prod     = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        shifted  = prod >>> FRAC_BITS;
        fits     = (&shifted[PW-1:SW-1]) || !(|shifted[PW-1:SW-1]);
        if (fits) begin
            sat_val = shifted[SW-1:0];
        end else if (shifted[PW-1]) begin
            sat_val = SAT_MIN;
        end else begin
            sat_val = SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NDIG);
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - 1'b1;
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_a_reg <= DW'(abs_a);
            mag_b_reg <= DW'(abs_b);
            neg_reg   <= a[SW-1] ^ b[SW-1];
            acc_reg   <= '0;
        end else if (busy_reg && cnt_reg != '0) begin
            acc_reg   <= acc_next;
            mag_b_reg <= {mag_b_reg[DW-DGW-1:0], {DGW{1'b0}}};
        end else if (busy_reg) begin
            res_reg   <= sat_val;
        end
    end

    assign busy   = busy_reg;
    assign result = res_reg;

endmodule

// ===== src/dse_datapath.sv =====
// Datapath: registers, state, operand selection and saturating write-back.
module dse_datapath #(
    parameter int FRAC_BITS   = dse_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = dse_pkg::STATE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dse_pkg::dse_cmd_t                     cmd,
    output dse_pkg::dse_sts_t                     sts,
    input  logic signed [dse_pkg::VALUE_W-1:0]    s_value,
    input  logic                                  cfg_we,
    input  logic [dse_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dse_pkg::CFG_W-1:0]             cfg_wdata,
    output logic signed [dse_pkg::COND_W-1:0]     m_conductance
);

    localparam int SW = STATE_WIDTH;
    localparam int CD = dse_pkg::COND_W;

    localparam logic signed [SW-1:0] ONE     = SW'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [CD-1:0] C_MAX   = {1'b0, {(CD-1){1'b1}}};
    localparam logic signed [CD-1:0] C_MIN   = {1'b1, {(CD-1){1'b0}}};

    function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] x,
                                                     input logic signed [SW-1:0] y);
        logic signed [SW:0] s;
        s = {x[SW-1], x} + {y[SW-1], y};
        if (s[SW] != s[SW-1]) begin
            return s[SW] ? SAT_MIN : SAT_MAX;
        end
        return s[SW-1:0];
    endfunction

    logic signed [SW-1:0] act_reg, mod_reg, x_reg, y_reg, t_reg;
    logic signed [dse_pkg::VALUE_W-1:0] val_reg;
    logic signed [dse_pkg::CFG_W-1:0]   drive_gain_reg, y_gain_reg, peak_norm_reg;
    logic [dse_pkg::DECAY_W-1:0]        x_decay_reg, y_decay_reg;
    logic signed [CD-1:0]               cond_reg;

    logic signed [SW-1:0] mul_a, mul_b, mul_res;
    logic                 mul_busy;
    logic                 fits32;
    logic signed [CD-1:0] cond_sat;

    always_comb begin
        case (cmd.op)
            dse_pkg::OP_MOD: begin mul_a = mod_reg; mul_b = SW'(val_reg);        end
            dse_pkg::OP_MA:  begin mul_a = mod_reg; mul_b = act_reg;             end
            dse_pkg::OP_DRV: begin mul_a = t_reg;   mul_b = SW'(drive_gain_reg); end
            dse_pkg::OP_XD:  begin mul_a = x_reg;   mul_b = SW'(x_decay_reg);    end
            dse_pkg::OP_YG:  begin mul_a = x_reg;   mul_b = SW'(y_gain_reg);     end
            dse_pkg::OP_YD:  begin mul_a = y_reg;   mul_b = SW'(y_decay_reg);    end
            dse_pkg::OP_PK:  begin mul_a = y_reg;   mul_b = SW'(peak_norm_reg);  end
            default:         begin mul_a = '0;      mul_b = '0;                  end
        endcase
        fits32   = (&mul_res[SW-1:CD-1]) || !(|mul_res[SW-1:CD-1]);
        cond_sat = fits32 ? mul_res[CD-1:0] : (mul_res[SW-1] ? C_MIN : C_MAX);
    end

    dse_mul #(
        .FRAC_BITS   (FRAC_BITS),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .result  (mul_res)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_gain_reg <= dse_pkg::DRIVE_GAIN_RST;
            x_decay_reg    <= dse_pkg::X_DECAY_RST;
            y_gain_reg     <= dse_pkg::Y_GAIN_RST;
            y_decay_reg    <= dse_pkg::Y_DECAY_RST;
            peak_norm_reg  <= dse_pkg::PEAK_NORM_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                dse_pkg::REG_DRIVE_GAIN: drive_gain_reg <= cfg_wdata;
                dse_pkg::REG_X_DECAY:    x_decay_reg    <= cfg_wdata[dse_pkg::DECAY_W-1:0];
                dse_pkg::REG_Y_GAIN:     y_gain_reg     <= cfg_wdata;
                dse_pkg::REG_Y_DECAY:    y_decay_reg    <= cfg_wdata[dse_pkg::DECAY_W-1:0];
                dse_pkg::REG_PEAK_NORM:  peak_norm_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // synapse state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            act_reg <= '0;
            mod_reg <= ONE;
            x_reg   <= '0;
            y_reg   <= '0;
        end else if (cmd.act_add) begin
            act_reg <= sat_add(act_reg, SW'(s_value));
        end else if (cmd.wb) begin
            case (cmd.op)
                dse_pkg::OP_MOD: mod_reg <= mul_res;
                dse_pkg::OP_XD:  x_reg   <= sat_add(t_reg, mul_res);
                dse_pkg::OP_YD:  y_reg   <= sat_add(t_reg, mul_res);
                dse_pkg::OP_PK: begin
                    act_reg <= '0;
                    mod_reg <= ONE;
                end
                default: ;
            endcase
        end
    end

    // operand and result holding
    always_ff @(posedge aclk) begin
        if (cmd.load_val) begin
            val_reg <= s_value;
        end
        if (cmd.wb) begin
            case (cmd.op)
                dse_pkg::OP_MA, dse_pkg::OP_DRV, dse_pkg::OP_YG: t_reg    <= mul_res;
                dse_pkg::OP_PK:                                  cond_reg <= cond_sat;
                default: ;
            endcase
        end
    end

    assign sts.mul_busy  = mul_busy;
    assign m_conductance = cond_reg;

endmodule

// ===== src/dse_ctrl.sv =====
// Controller: accepts items, sequences the multiply steps, owns the output valid.
module dse_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    output logic              m_valid,
    input  logic              m_ready,
    output dse_pkg::dse_cmd_t cmd,
    input  dse_pkg::dse_sts_t sts
);

    dse_pkg::state_t state_reg, state_next;
    dse_pkg::op_t    op_reg, op_next;
    logic            m_valid_reg, m_valid_next;
    logic            emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dse_pkg::ST_IDLE;
            op_reg      <= dse_pkg::OP_MOD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.op     = op_reg;
        case (state_reg)
            dse_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_val = 1'b1;
                    case (dse_pkg::kind_t'(s_kind))
                        dse_pkg::KIND_ADD:   cmd.act_add = 1'b1;
                        dse_pkg::KIND_MOD: begin
                            op_next    = dse_pkg::OP_MOD;
                            state_next = dse_pkg::ST_MUL_GO;
                        end
                        dse_pkg::KIND_TICK: begin
                            op_next    = dse_pkg::OP_MA;
                            state_next = dse_pkg::ST_MUL_GO;
                        end
                        dse_pkg::KIND_CLEAR: cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            dse_pkg::ST_MUL_GO: begin
                cmd.mul_start = 1'b1;
                state_next    = dse_pkg::ST_MUL_WAIT;
            end
            dse_pkg::ST_MUL_WAIT: begin
                // final step holds until the output register is free
                if (!sts.mul_busy &&
                    (op_reg != dse_pkg::OP_PK || !m_valid_reg || m_ready)) begin
                    cmd.wb     = 1'b1;
                    state_next = dse_pkg::ST_MUL_GO;
                    case (op_reg)
                        dse_pkg::OP_MOD: state_next = dse_pkg::ST_IDLE;
                        dse_pkg::OP_MA:  op_next    = dse_pkg::OP_DRV;
                        dse_pkg::OP_DRV: op_next    = dse_pkg::OP_XD;
                        dse_pkg::OP_XD:  op_next    = dse_pkg::OP_YG;
                        dse_pkg::OP_YG:  op_next    = dse_pkg::OP_YD;
                        dse_pkg::OP_YD:  op_next    = dse_pkg::OP_PK;
                        dse_pkg::OP_PK:  state_next = dse_pkg::ST_IDLE;
                        default:         state_next = dse_pkg::ST_IDLE;
                    endcase
                end
            end
            default: state_next = dse_pkg::ST_IDLE;
        endcase
        emit = cmd.wb && (op_reg == dse_pkg::OP_PK);
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_idle_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sts.mul_busy)
        else $error("item taken while multiplier busy");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wb && cmd.op == dse_pkg::OP_PK) |-> (!m_valid_reg || m_ready))
        else $error("result overwrites an untaken conductance");

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |=> sts.mul_busy)
        else $error("multiplier did not start");

endmodule

// ===== src/dual_exponential_synapse_core.sv =====
// Top level of the dual-exponential synaptic conductance core.
//
// Input channel (s_valid/s_ready, s_kind, s_value): activation adds s_value to
// the accumulator, modulation multiplies the gain by s_value, a tick advances
// both first-order stages and yields one conductance, a clear restores the
// state to its reset values. One transfer is taken at a time.
// Result channel (m_valid/m_ready, m_conductance): one transfer per tick,
// saturated signed fixed point with FRAC_BITS fractional bits.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at the edge;
// indexes above peak_norm are ignored. Write only while the core is idle.
// Each multiply works on NDIG = ceil(STATE_WIDTH/16) digits (3 by default).
// Activations and clears are applied at the edge that takes them; a
// modulation is one multiply and a tick six. Each multiply issues, runs one
// digit per cycle on the shared multiplier, finishes and writes back.
// The conductance sits in an output register, so further items are taken
// while it waits; a following tick holds at its last step if the receiver
// stalls. Reset (aresetn low, synchronous) restores configuration registers and state.
module dual_exponential_synapse_core #(
    parameter int FRAC_BITS   = dse_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = dse_pkg::STATE_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_kind,
    input  logic signed [dse_pkg::VALUE_W-1:0] s_value,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [dse_pkg::COND_W-1:0]  m_conductance,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [dse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dse_pkg::CFG_W-1:0]          cfg_wdata
);

    dse_pkg::dse_cmd_t cmd;
    dse_pkg::dse_sts_t sts;

    // sequencing and handshakes
    dse_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // state, coefficients and the shared multiplier
    dse_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_value       (s_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .m_conductance (m_conductance)
    );

endmodule

// ===== tb/synapse_tb_pkg.sv =====
// Conductance scoreboard: bit-accurate prediction and in-order result checking.
package synapse_tb_pkg;
    import dse_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int SW   = STATE_WIDTH_DEF;

    typedef logic signed [SW-1:0]     state_word_t;
    typedef logic signed [COND_W-1:0] cond_t;

    localparam state_word_t STATE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam state_word_t STATE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam state_word_t GAIN_ONE  = state_word_t'(1) << FRAC;
    localparam cond_t       COND_MAX  = {1'b0, {(COND_W-1){1'b1}}};
    localparam cond_t       COND_MIN  = {1'b1, {(COND_W-1){1'b0}}};

    class conductance_scoreboard;
        logic signed [CFG_W-1:0] drive_gain, y_gain, peak_norm;
        logic [DECAY_W-1:0]      x_decay, y_decay;
        state_word_t             activation_sum, modulation_gain, stage_x, stage_y;
        cond_t                   expected_conductance[$];
        int                      mismatches, results_checked, ticks_noted;

        function new();
            drive_gain      = DRIVE_GAIN_RST;
            x_decay         = X_DECAY_RST;
            y_gain          = Y_GAIN_RST;
            y_decay         = Y_DECAY_RST;
            peak_norm       = PEAK_NORM_RST;
            mismatches      = 0;
            results_checked = 0;
            ticks_noted     = 0;
            clear_state();
        endfunction

        function void clear_state();
            activation_sum  = '0;
            modulation_gain = GAIN_ONE;
            stage_x         = '0;
            stage_y         = '0;
        endfunction

        // exact product, floor shift by FRAC, saturate to the state width
        function state_word_t scaled_product(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [127:0] prod;
            prod = a * b;
            prod = prod >>> FRAC;
            if (prod[127:SW-1] != {(129-SW){prod[127]}})
                return prod[127] ? STATE_MIN : STATE_MAX;
            return prod[SW-1:0];
        endfunction

        function state_word_t clamped_sum(state_word_t a, state_word_t b);
            logic signed [SW:0] s;
            s = a + b;
            if (s[SW] != s[SW-1])
                return s[SW] ? STATE_MIN : STATE_MAX;
            return s[SW-1:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_DRIVE_GAIN: drive_gain = data;
                REG_X_DECAY:    x_decay    = data[DECAY_W-1:0];
                REG_Y_GAIN:     y_gain     = data;
                REG_Y_DECAY:    y_decay    = data[DECAY_W-1:0];
                REG_PEAK_NORM:  peak_norm  = data;
                default: ;
            endcase
        endfunction

        function void note_input(kind_t kind, logic signed [VALUE_W-1:0] value);
            state_word_t g;
            case (kind)
                KIND_ADD: activation_sum = clamped_sum(activation_sum, value);
                KIND_MOD: modulation_gain = scaled_product(modulation_gain, value);
                KIND_TICK: begin
                    stage_x = clamped_sum(
                        scaled_product(scaled_product(modulation_gain, activation_sum),
                                       drive_gain),
                        scaled_product(stage_x, x_decay));
                    stage_y = clamped_sum(scaled_product(stage_x, y_gain),
                                          scaled_product(stage_y, y_decay));
                    g = scaled_product(stage_y, peak_norm);
                    if (g[SW-1:COND_W-1] != {(SW-COND_W+1){g[SW-1]}})
                        expected_conductance.push_back(g[SW-1] ? COND_MIN : COND_MAX);
                    else
                        expected_conductance.push_back(g[COND_W-1:0]);
                    activation_sum  = '0;
                    modulation_gain = GAIN_ONE;
                    ticks_noted++;
                end
                default: clear_state();
            endcase
        endfunction

        task report_mismatch(string what, cond_t got, cond_t want);
            mismatches++;
            $display("MISMATCH %s: got %0d, wanted %0d (result %0d)",
                     what, got, want, results_checked);
        endtask

        task check_result(cond_t got);
            cond_t want;
            results_checked++;
            if (expected_conductance.size() == 0) begin
                report_mismatch("conductance with no tick outstanding", got, '0);
                return;
            end
            want = expected_conductance.pop_front();
            if (got !== want)
                report_mismatch("conductance", got, want);
        endtask

        function int pending();
            return expected_conductance.size();
        endfunction
    endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for the dual-exponential synapse core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dse_pkg::*;
    import synapse_tb_pkg::*;

    // Fixed-point operand shorthands (FRAC_BITS = 16)
    localparam logic signed [VALUE_W-1:0] ONE       = 32'sd65536;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFFFFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

    // Indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_PEAK_NORM + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    localparam int RANDOM_PER_PHASE = 220;
    localparam int NUM_PHASES       = 6;
    localparam int TAIL_CYCLES      = 48;    // longest op is a tick
    localparam int LONG_HOLD        = 600;   // result side held off this long once
    localparam int WATCHDOG_LIMIT   = 2000;  // cycles without any transfer

    logic                        aclk;
    logic                        aresetn   = 1'b0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic [1:0]                  s_kind    = '0;
    logic signed [VALUE_W-1:0]   s_value   = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic signed [COND_W-1:0]    m_conductance;
    logic                        cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]            cfg_wdata = '0;

    conductance_scoreboard sb;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int transfers_in  = 0;
    int cfg_sets      = 0;

    dual_exponential_synapse_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_conductance (m_conductance),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Uniform signed value in [-mag, mag]
    function automatic int signed_within(input int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    // Decay register image: 17-bit field with junk in the unused upper bits,
    // so the write port's truncation gets exercised too
    function automatic logic [CFG_W-1:0] decay_word(input logic [DECAY_W-1:0] d);
        logic [CFG_W-DECAY_W-1:0] upper;
        upper = (CFG_W-DECAY_W)'($urandom());
        return {upper, d};
    endfunction

    // Operand mix: mostly moderate values near the useful range (gains close to
    // 1.0, activations of a few units), some raw 32-bit patterns, some extremes.
    function automatic logic signed [VALUE_W-1:0] pick_operand(input kind_t kind);
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       v = VALUE_MAX;
                    1:       v = VALUE_MIN;
                    2:       v = '0;
                    3:       v = -1;
                    4:       v = 1;
                    default: v = ONE;
                endcase
            end
            1, 2:    v = $urandom();
            default: v = (kind == KIND_MOD) ? ONE + signed_within(ONE / 2)
                                            : signed_within(4 * ONE);
        endcase
        return v;
    endfunction

    // One input transfer. A random gap may come first; valid is only dropped
    // when a gap is actually taken, so back-to-back items keep it high.
    task automatic send_item(input kind_t kind, input logic signed [VALUE_W-1:0] value);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(kind, value);
        transfers_in++;
    endtask

    // One register write; cfg_we is left high for a following write
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // Full register set, then a write to a non-existent index which the core
    // has to ignore. The stray write goes last so aliasing would show up.
    task automatic program_regs(input logic [CFG_W-1:0] dg, xd, yg, yd, pk);
        put_reg(REG_DRIVE_GAIN, dg);
        put_reg(REG_X_DECAY,    xd);
        put_reg(REG_Y_GAIN,     yg);
        put_reg(REG_Y_DECAY,    yd);
        put_reg(REG_PEAK_NORM,  pk);
        put_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), $urandom());
        cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    // Wait for every outstanding conductance, then allow a trailing
    // modulation or clear to finish before registers may be touched.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Edge cases with a hand-picked register set
    task automatic run_directed();
        send_item(KIND_ADD,   ONE);
        send_item(KIND_TICK,  32'sh5A5A5A5A);      // operand ignored on a tick
        send_item(KIND_ADD,   VALUE_MAX);
        send_item(KIND_ADD,   VALUE_MAX);
        send_item(KIND_TICK,  '0);
        send_item(KIND_ADD,   VALUE_MIN);
        send_item(KIND_TICK,  -1);
        send_item(KIND_MOD,   '0);                 // zero gain
        send_item(KIND_ADD,   ONE);
        send_item(KIND_TICK,  '0);
        send_item(KIND_MOD,   -ONE);               // negative gain
        send_item(KIND_ADD,   2 * ONE);
        send_item(KIND_TICK,  '0);
        send_item(KIND_MOD,   VALUE_MAX);          // large gain; the tick drives the state into saturation
        send_item(KIND_MOD,   VALUE_MAX);
        send_item(KIND_ADD,   VALUE_MAX);
        send_item(KIND_TICK,  '0);                 // conductance clips high
        send_item(KIND_MOD,   VALUE_MIN);
        send_item(KIND_ADD,   VALUE_MAX);
        send_item(KIND_TICK,  '0);                 // conductance still clips high
        send_item(KIND_CLEAR, 32'shA5A5A5A5);      // clear keeps registers
        send_item(KIND_TICK,  '0);                 // tick straight after a clear
        send_item(KIND_MOD,   1);                  // smallest gain, floor rounding
        send_item(KIND_ADD,   -1);
        send_item(KIND_TICK,  '0);
    endtask

    // Mostly well-formed bursts (a few activations/modulations closed by a
    // tick), with some lone items of any kind and the odd clear as noise.
    task automatic run_random(input int n);
        int target;
        int r;
        int burst;
        target = transfers_in + n;
        while (transfers_in < target) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                burst = $urandom_range(0, 5);
                repeat (burst) begin
                    if ($urandom_range(0, 3) == 0)
                        send_item(KIND_MOD, pick_operand(KIND_MOD));
                    else
                        send_item(KIND_ADD, pick_operand(KIND_ADD));
                end
                send_item(KIND_TICK, $urandom());
            end else if (r < 92) begin
                send_item(kind_t'($urandom_range(0, 3)), $urandom());
            end else begin
                send_item(KIND_CLEAR, $urandom());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern, with one long hold-off that
    // backs the core up until it refuses further input.
    // ------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Monitor and watchdog. Signals are read straight after the edge, before
    // any nonblocking update of that edge lands, i.e. the values the core saw.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_conductance);
            if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("dual_exponential_synapse_core verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int phase;
        sb = new();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Opening idling mix: sender gaps 26%, receiver stalls 45%
        send_idle_pct = 26;
        recv_idle_pct = 45;

        // Register reset values: y_gain is zero, so every conductance is zero
        send_item(KIND_ADD,  ONE);
        send_item(KIND_TICK, '0);
        send_item(KIND_MOD,  2 * ONE);
        send_item(KIND_TICK, '0);
        settle();

        // Directed cases: unit drive, half decays, unit coupling and norm
        program_regs(ONE, decay_word(17'd32768), ONE, decay_word(17'd32768), ONE);
        run_directed();
        settle();

        // Random phases, each with its own register set and idling mix
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 2) begin
                send_idle_pct = 26;
                recv_idle_pct = 45;
            end else if (phase < 4) begin
                send_idle_pct = 45;
                recv_idle_pct = 26;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case (phase)
                0: program_regs(32'd131072, decay_word(17'd58982), 32'd6554,
                                decay_word(17'd62259), 32'd98304);
                // largest values: decays above one, everything saturates
                1: program_regs(VALUE_MAX, decay_word('1), VALUE_MAX,
                                decay_word('1), VALUE_MAX);
                // most negative coefficients, zero decays
                2: program_regs(VALUE_MIN, decay_word('0), VALUE_MIN,
                                decay_word('0), VALUE_MIN);
                3: program_regs(signed_within(8 * ONE),
                                decay_word(DECAY_W'($urandom_range(0, ONE))),
                                signed_within(2 * ONE),
                                decay_word(DECAY_W'($urandom_range(0, ONE))),
                                signed_within(4 * ONE));
                4: program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                default: program_regs(ONE, decay_word(17'd65536), 32'd32768,
                                      decay_word(17'd65536), -ONE);
            endcase

            // Back-pressure episode: receiver goes quiet while input keeps coming
            if (phase == 4)
                hold_left = LONG_HOLD;

            run_random(RANDOM_PER_PHASE);
            settle();
        end

        $display("Summary: %0d input transfers incl. %0d ticks, %0d conductance results checked",
                 transfers_in, sb.ticks_noted, sb.results_checked);
        $display("Summary: %0d register sets incl. both extremes, one long result-side hold",
                 cfg_sets);
        if (sb.mismatches == 0) begin
            $display("dual_exponential_synapse_core verification clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("dual_exponential_synapse_core verification failed");
        end
        $finish;
    end

endmodule
